@@ rtl/assert_macros.svh @@
// Assertion helpers used by the gate motor sequencer top
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every rising clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rstn, expr) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) \
        else $error("assertion failed");

// Check that a condition implies another in the same cycle
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("implication failed");

`endif

@@ rtl/gms_pkg.sv @@
package gms_pkg;

    // Duty width default
    localparam int DUTY_BITS_DEF = 8;

    // Configuration port widths
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 16;

    // Register reset values
    localparam logic [15:0] TIMEOUT_MS_RST       = 16'd25000;
    localparam logic [7:0]  SLOW_DUTY_RST        = 8'd40;
    localparam logic [15:0] SUPPLY_SETTLE_MS_RST = 16'd1000;
    localparam logic [15:0] DIR_SETTLE_MS_RST    = 16'd500;
    localparam logic [7:0]  RAMP_STEP_MS_RST     = 8'd10;
    localparam logic [15:0] STOP_HOLD_MS_RST     = 16'd2000;
    localparam logic [15:0] FULL_RUN_MS_RST      = 16'd7000;
    localparam logic [15:0] PARTIAL_HOLD_MS_RST  = 16'd1000;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_TIMEOUT       = 4'd0,
        CFG_SLOW_DUTY     = 4'd1,
        CFG_SUPPLY_SETTLE = 4'd2,
        CFG_DIR_SETTLE    = 4'd3,
        CFG_RAMP_STEP     = 4'd4,
        CFG_STOP_HOLD     = 4'd5,
        CFG_FULL_RUN      = 4'd6,
        CFG_PARTIAL_HOLD  = 4'd7
    } cfg_reg_e;

    // Sequence phases
    typedef enum logic [3:0] {
        PH_IDLE          = 4'd0,
        PH_WAIT_RELEASE  = 4'd1,
        PH_SUPPLY_SETTLE = 4'd2,
        PH_DIR_SETTLE    = 4'd3,
        PH_RAMP_RELEASE  = 4'd4,
        PH_RAMP_CLOSE    = 4'd5,
        PH_PARTIAL_HOLD  = 4'd6,
        PH_PARTIAL_DONE  = 4'd7,
        PH_FULL_RUN      = 4'd8,
        PH_SLOW_RUN      = 4'd9,
        PH_CLOSE_RUN     = 4'd10,
        PH_STOP_HOLD     = 4'd11
    } phase_t;

    // Kind of motion in progress
    typedef enum logic [1:0] {
        KIND_NONE    = 2'd0,
        KIND_PARTIAL = 2'd1,
        KIND_FULL    = 2'd2,
        KIND_CLOSE   = 2'd3
    } motion_kind_t;

    // Remainder unit request and response
    typedef struct packed {
        logic        start;
        logic [15:0] dividend;
        logic [7:0]  divisor;
    } rem_req_t;

    typedef struct packed {
        logic       busy;
        logic       done;
        logic [7:0] rem;
    } rem_rsp_t;

    // Saturating 16-bit increment
    function automatic logic [15:0] inc16(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    // Step length with zero taken as one
    function automatic logic [7:0] step_len(input logic [7:0] v);
        return (v == 8'd0) ? 8'd1 : v;
    endfunction

endpackage

@@ rtl/gms_rem_unit.sv @@
// Bit-serial remainder of a 16-bit count by an 8-bit step length
module gms_rem_unit (
    input  logic              aclk,
    input  logic              aresetn,
    input  gms_pkg::rem_req_t req,
    output gms_pkg::rem_rsp_t rsp
);

    logic        active_reg;
    logic        done_reg;
    logic [3:0]  bit_cnt_reg;
    logic [15:0] shift_reg;
    logic [7:0]  div_reg;
    logic [7:0]  rem_reg;
    logic [8:0]  trial;
    logic [7:0]  rem_next;

    // One restoring step: bring down a bit, subtract if it fits
    always_comb begin
        trial = {rem_reg, shift_reg[15]};
        if (trial >= {1'b0, div_reg}) begin
            rem_next = 8'(trial - {1'b0, div_reg});
        end else begin
            rem_next = trial[7:0];
        end
    end

    // Control: run sixteen steps, then flag done for one cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg  <= 1'b0;
            done_reg    <= 1'b0;
            bit_cnt_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                active_reg  <= 1'b1;
                bit_cnt_reg <= '0;
            end else if (active_reg) begin
                bit_cnt_reg <= bit_cnt_reg + 4'd1;
                if (bit_cnt_reg == 4'd15) begin
                    active_reg <= 1'b0;
                    done_reg   <= 1'b1;
                end
            end
        end
    end

    // Datapath: load operands, then shift through
    always_ff @(posedge aclk) begin
        if (req.start) begin
            shift_reg <= req.dividend;
            div_reg   <= req.divisor;
            rem_reg   <= '0;
        end else if (active_reg) begin
            shift_reg <= {shift_reg[14:0], 1'b0};
            rem_reg   <= rem_next;
        end
    end

    assign rsp.busy = active_reg;
    assign rsp.done = done_reg;
    assign rsp.rem  = rem_reg;

endmodule

@@ rtl/gate_motor_sequencer_top.sv @@
// A result is registered in the output register in the cycle after its tick item is accepted.
// One tick item is taken per cycle while the output side takes results and the
// remainder unit is idle. A write to the ramp step register recomputes the close-run
// step phase in the remainder unit; items and writes are held off until it is done.
// Reset (synchronous, active low) restores register defaults and the idle phase.
`include "assert_macros.svh"
module gate_motor_sequencer_top #(
    parameter int DUTY_BITS = gms_pkg::DUTY_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // tick input
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_partial_open_button,
    input  logic                           s_full_open_button,
    input  logic                           s_close_button,
    input  logic                           s_stop_button,
    input  logic                           s_limit_switch,
    // result output
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [DUTY_BITS-1:0]           m_pwm_duty,
    output logic                           m_direction_close,
    output logic                           m_supply_on,
    output logic                           m_motor_stopped,
    output logic [3:0]                     m_phase,
    // configuration writes
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [gms_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [gms_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam logic [DUTY_BITS-1:0] DUTY_MAX = '1;
    localparam int CMP_W = (DUTY_BITS > 8) ? DUTY_BITS : 8;

    // configuration registers
    logic [15:0] timeout_ms_reg;
    logic [7:0]  slow_duty_reg;
    logic [15:0] supply_settle_ms_reg;
    logic [15:0] dir_settle_ms_reg;
    logic [7:0]  ramp_step_ms_reg;
    logic [15:0] stop_hold_ms_reg;
    logic [15:0] full_run_ms_reg;
    logic [15:0] partial_hold_ms_reg;

    // sequence state
    gms_pkg::phase_t       phase_reg, phase_next;
    gms_pkg::motion_kind_t kind_reg, kind_next;
    logic [15:0]           phase_timer_reg, phase_timer_next;
    logic [15:0]           press_timer_reg, press_timer_next;
    logic                  press_armed_reg, press_armed_next;
    logic [DUTY_BITS-1:0]  duty_reg, duty_next;
    logic                  direction_reg, direction_next;
    logic                  supply_reg, supply_next;
    logic                  stopped_reg, stopped_next;
    logic                  close_last_reg;
    logic [7:0]            step_rem_reg, step_rem_next;

    logic              s_fire;
    logic              cfg_fire;
    gms_pkg::rem_req_t rem_req;
    gms_pkg::rem_rsp_t rem_rsp;

    logic [7:0]           step;
    logic [DUTY_BITS-1:0] slow_val;
    logic [CMP_W-1:0]     slow_ext;
    logic [15:0]          pt_inc;
    logic [7:0]           rem_plus;
    logic                 rem_wrap;
    logic                 cedge;
    logic                 tmo;
    logic                 brk;

    assign s_fire    = s_valid && s_ready;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign s_ready   = !rem_rsp.busy && !rem_rsp.done && (!m_valid || m_ready);
    assign cfg_ready = !rem_rsp.busy && !rem_rsp.done;

    // recompute the close-run step phase whenever the ramp step register is written
    assign rem_req.start    = cfg_fire && (cfg_index == gms_pkg::CFG_RAMP_STEP);
    assign rem_req.dividend = phase_timer_reg;
    assign rem_req.divisor  = gms_pkg::step_len(cfg_data[7:0]);

    gms_rem_unit u_rem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (rem_req),
        .rsp     (rem_rsp)
    );

    // configuration register file
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_ms_reg       <= gms_pkg::TIMEOUT_MS_RST;
            slow_duty_reg        <= gms_pkg::SLOW_DUTY_RST;
            supply_settle_ms_reg <= gms_pkg::SUPPLY_SETTLE_MS_RST;
            dir_settle_ms_reg    <= gms_pkg::DIR_SETTLE_MS_RST;
            ramp_step_ms_reg     <= gms_pkg::RAMP_STEP_MS_RST;
            stop_hold_ms_reg     <= gms_pkg::STOP_HOLD_MS_RST;
            full_run_ms_reg      <= gms_pkg::FULL_RUN_MS_RST;
            partial_hold_ms_reg  <= gms_pkg::PARTIAL_HOLD_MS_RST;
        end else if (cfg_fire) begin
            case (cfg_index)
                gms_pkg::CFG_TIMEOUT:       timeout_ms_reg       <= cfg_data;
                gms_pkg::CFG_SLOW_DUTY:     slow_duty_reg        <= cfg_data[7:0];
                gms_pkg::CFG_SUPPLY_SETTLE: supply_settle_ms_reg <= cfg_data;
                gms_pkg::CFG_DIR_SETTLE:    dir_settle_ms_reg    <= cfg_data;
                gms_pkg::CFG_RAMP_STEP:     ramp_step_ms_reg     <= cfg_data[7:0];
                gms_pkg::CFG_STOP_HOLD:     stop_hold_ms_reg     <= cfg_data;
                gms_pkg::CFG_FULL_RUN:      full_run_ms_reg      <= cfg_data;
                gms_pkg::CFG_PARTIAL_HOLD:  partial_hold_ms_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // derived values
    assign step     = gms_pkg::step_len(ramp_step_ms_reg);
    assign slow_ext = CMP_W'(slow_duty_reg);
    assign slow_val = (slow_ext > CMP_W'(DUTY_MAX)) ? DUTY_MAX : DUTY_BITS'(slow_ext);
    assign pt_inc   = gms_pkg::inc16(phase_timer_reg);
    assign rem_plus = step_rem_reg + 8'd1;
    assign rem_wrap = (rem_plus == step);
    assign cedge    = s_close_button && !close_last_reg;

    // next state for one tick
    always_comb begin
        phase_next       = phase_reg;
        kind_next        = kind_reg;
        phase_timer_next = phase_timer_reg;
        press_timer_next = press_timer_reg;
        press_armed_next = press_armed_reg;
        duty_next        = duty_reg;
        direction_next   = direction_reg;
        supply_next      = supply_reg;
        stopped_next     = stopped_reg;
        step_rem_next    = step_rem_reg;
        brk              = 1'b0;

        if (press_armed_reg) begin
            press_timer_next = gms_pkg::inc16(press_timer_reg);
        end
        tmo = press_armed_reg && (press_timer_next >= timeout_ms_reg);

        case (phase_reg)
            gms_pkg::PH_IDLE, gms_pkg::PH_PARTIAL_DONE, gms_pkg::PH_SLOW_RUN: begin
                if (s_partial_open_button || s_full_open_button || cedge) begin
                    stopped_next     = 1'b0;
                    press_timer_next = '0;
                    press_armed_next = 1'b1;
                    phase_timer_next = '0;
                    if (s_partial_open_button) begin
                        kind_next  = gms_pkg::KIND_PARTIAL;
                        phase_next = gms_pkg::PH_WAIT_RELEASE;
                    end else if (s_full_open_button) begin
                        kind_next  = gms_pkg::KIND_FULL;
                        phase_next = gms_pkg::PH_WAIT_RELEASE;
                    end else begin
                        kind_next   = gms_pkg::KIND_CLOSE;
                        supply_next = 1'b1;
                        phase_next  = gms_pkg::PH_SUPPLY_SETTLE;
                    end
                end else if ((!stopped_reg && (s_limit_switch || s_stop_button)) || tmo) begin
                    duty_next        = '0;
                    stopped_next     = 1'b1;
                    press_armed_next = 1'b0;
                    press_timer_next = '0;
                    kind_next        = gms_pkg::KIND_NONE;
                    phase_next       = gms_pkg::PH_STOP_HOLD;
                    phase_timer_next = '0;
                end
            end
            gms_pkg::PH_WAIT_RELEASE: begin
                if (!((kind_reg == gms_pkg::KIND_PARTIAL) ? s_partial_open_button
                                                          : s_full_open_button)) begin
                    supply_next      = 1'b1;
                    phase_next       = gms_pkg::PH_SUPPLY_SETTLE;
                    phase_timer_next = '0;
                end
            end
            gms_pkg::PH_SUPPLY_SETTLE: begin
                phase_timer_next = pt_inc;
                if (pt_inc >= supply_settle_ms_reg) begin
                    direction_next   = (kind_reg == gms_pkg::KIND_CLOSE);
                    phase_next       = gms_pkg::PH_DIR_SETTLE;
                    phase_timer_next = '0;
                end
            end
            gms_pkg::PH_DIR_SETTLE: begin
                phase_timer_next = pt_inc;
                if (pt_inc >= dir_settle_ms_reg) begin
                    phase_timer_next = '0;
                    if (kind_reg == gms_pkg::KIND_CLOSE) begin
                        duty_next     = slow_val;
                        step_rem_next = '0;
                        phase_next    = gms_pkg::PH_CLOSE_RUN;
                    end else begin
                        duty_next  = '0;
                        phase_next = gms_pkg::PH_RAMP_RELEASE;
                    end
                end
            end
            gms_pkg::PH_RAMP_RELEASE, gms_pkg::PH_RAMP_CLOSE: begin
                phase_timer_next = pt_inc;
                if (pt_inc >= {8'h00, step}) begin
                    phase_timer_next = '0;
                    brk = ((phase_reg == gms_pkg::PH_RAMP_RELEASE) ? !s_limit_switch
                                                                   : s_limit_switch)
                          || s_stop_button || tmo;
                    if (brk && (phase_reg == gms_pkg::PH_RAMP_RELEASE)) begin
                        phase_next = gms_pkg::PH_RAMP_CLOSE;
                    end else if (brk || (duty_reg == DUTY_MAX)) begin
                        duty_next  = DUTY_MAX;
                        phase_next = (kind_reg == gms_pkg::KIND_PARTIAL)
                                     ? gms_pkg::PH_PARTIAL_HOLD : gms_pkg::PH_FULL_RUN;
                    end else begin
                        duty_next = duty_reg + DUTY_BITS'(1);
                    end
                end
            end
            gms_pkg::PH_PARTIAL_HOLD: begin
                duty_next = DUTY_MAX;
                if (s_limit_switch || s_stop_button || tmo ||
                    (phase_timer_reg >= partial_hold_ms_reg)) begin
                    duty_next        = '0;
                    phase_next       = gms_pkg::PH_PARTIAL_DONE;
                    phase_timer_next = '0;
                end else begin
                    phase_timer_next = pt_inc;
                end
            end
            gms_pkg::PH_FULL_RUN: begin
                phase_timer_next = pt_inc;
                if (s_limit_switch || s_stop_button || tmo || (pt_inc >= full_run_ms_reg)) begin
                    duty_next        = slow_val;
                    phase_next       = gms_pkg::PH_SLOW_RUN;
                    phase_timer_next = '0;
                end
            end
            gms_pkg::PH_CLOSE_RUN: begin
                // step phase tracks the run time modulo the step length
                duty_next        = slow_val;
                phase_timer_next = pt_inc;
                step_rem_next    = rem_wrap ? 8'd0 : rem_plus;
                if (rem_wrap && (!s_limit_switch || s_stop_button || tmo ||
                                 (pt_inc >= {step, 8'h00}))) begin
                    phase_next       = gms_pkg::PH_SLOW_RUN;
                    phase_timer_next = '0;
                end
            end
            gms_pkg::PH_STOP_HOLD: begin
                duty_next        = '0;
                phase_timer_next = pt_inc;
                if (pt_inc >= stop_hold_ms_reg) begin
                    supply_next      = 1'b0;
                    phase_next       = gms_pkg::PH_IDLE;
                    phase_timer_next = '0;
                end
            end
            default: begin
                phase_next       = gms_pkg::PH_IDLE;
                phase_timer_next = '0;
            end
        endcase
    end

    // state registers: advance on each accepted item; a remainder result loads the step phase
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= gms_pkg::PH_IDLE;
            kind_reg        <= gms_pkg::KIND_NONE;
            phase_timer_reg <= '0;
            press_timer_reg <= '0;
            press_armed_reg <= 1'b0;
            duty_reg        <= '0;
            direction_reg   <= 1'b1;
            supply_reg      <= 1'b0;
            stopped_reg     <= 1'b0;
            close_last_reg  <= 1'b0;
            step_rem_reg    <= '0;
        end else if (rem_rsp.done) begin
            step_rem_reg <= rem_rsp.rem;
        end else if (s_fire) begin
            phase_reg       <= phase_next;
            kind_reg        <= kind_next;
            phase_timer_reg <= phase_timer_next;
            press_timer_reg <= press_timer_next;
            press_armed_reg <= press_armed_next;
            duty_reg        <= duty_next;
            direction_reg   <= direction_next;
            supply_reg      <= supply_next;
            stopped_reg     <= stopped_next;
            close_last_reg  <= s_close_button;
            step_rem_reg    <= step_rem_next;
        end
    end

    // output register: hold until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (s_fire) begin
            m_valid <= 1'b1;
        end else if (m_ready) begin
            m_valid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            m_pwm_duty        <= duty_next;
            m_direction_close <= direction_next;
            m_supply_on       <= supply_next;
            m_motor_stopped   <= stopped_next;
            m_phase           <= phase_next;
        end
    end

    // checks
    `ASSERT_IMPLIES(a_busy_blocks_items, aclk, aresetn, rem_rsp.busy, !s_ready && !cfg_ready)
    `ASSERT_IMPLIES(a_stopped_disarmed, aclk, aresetn, stopped_reg, !press_armed_reg)
    `ASSERT_IMPLIES(a_step_rem_in_range, aclk, aresetn,
        (phase_reg == gms_pkg::PH_CLOSE_RUN) && !rem_rsp.busy && !rem_rsp.done,
        step_rem_reg < step)
    `ASSERT_IMPLIES(a_supply_off_phases, aclk, aresetn, !supply_reg,
        (phase_reg == gms_pkg::PH_IDLE) || (phase_reg == gms_pkg::PH_WAIT_RELEASE) ||
        (phase_reg == gms_pkg::PH_STOP_HOLD))

endmodule

@@ verif/tb_gate_motor_sequencer_top.sv @@
module tb_gate_motor_sequencer_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DUTY_W          = gms_pkg::DUTY_BITS_DEF;
    localparam int DUTY_FULL       = (1 << DUTY_W) - 1;
    localparam int CLOSE_RUN_STEPS = 256;
    localparam int LONG_STALL      = 60;
    localparam logic [gms_pkg::CFG_INDEX_W-1:0] UNMAPPED_REG = 4'd15;

    typedef struct packed {
        logic partial_btn;
        logic full_btn;
        logic close_btn;
        logic stop_btn;
        logic limit;
    } tick_t;

    typedef struct packed {
        logic [DUTY_W-1:0] duty;
        logic              dir_close;
        logic              supply;
        logic              stopped;
        logic [3:0]        phase;
    } drive_t;

    // Clock and block ports
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic        s_valid               = 1'b0;
    logic        s_ready;
    logic        s_partial_open_button = 1'b0;
    logic        s_full_open_button    = 1'b0;
    logic        s_close_button        = 1'b0;
    logic        s_stop_button         = 1'b0;
    logic        s_limit_switch        = 1'b0;

    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [DUTY_W-1:0] m_pwm_duty;
    logic              m_direction_close;
    logic              m_supply_on;
    logic              m_motor_stopped;
    logic [3:0]        m_phase;

    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [gms_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [gms_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;

    gate_motor_sequencer_top dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Traffic shaping and bookkeeping
    int tx_idle_pct  = 30;
    int rx_idle_pct  = 74;
    int stall_orders = 0;
    int stall_seen   = 0;
    int stall_left   = 0;
    int ticks_sent   = 0;
    int results_seen = 0;
    int fail_count   = 0;

    drive_t expected_drive[$];

    // Sequencer mirror: configuration
    logic [15:0] timeout_lim, supply_wait, dir_wait, hold_before_off;
    logic [15:0] full_run_len, partial_hold_len;
    logic [7:0]  slow_level, step_ticks;

    // Sequencer mirror: state
    gms_pkg::phase_t       seq_phase;
    gms_pkg::motion_kind_t seq_kind;
    logic [15:0]           phase_ticks, press_ticks;
    bit                    press_armed, dir_close, supply_en, stop_done, close_prev;
    int                    duty_level;

    function automatic logic [15:0] sat_inc(input logic [15:0] v);
        return v + {15'd0, ~&v};
    endfunction

    function automatic int step_span();
        return (step_ticks == 8'd0) ? 1 : int'(step_ticks);
    endfunction

    function automatic int slow_target();
        return (slow_level > DUTY_FULL) ? DUTY_FULL : int'(slow_level);
    endfunction

    function automatic void enter_phase(input gms_pkg::phase_t p);
        seq_phase   = p;
        phase_ticks = '0;
    endfunction

    function automatic void begin_motion(input gms_pkg::motion_kind_t k);
        stop_done   = 1'b0;
        press_ticks = '0;
        press_armed = 1'b1;
        seq_kind    = k;
        if (k == gms_pkg::KIND_CLOSE) begin
            supply_en = 1'b1;
            enter_phase(gms_pkg::PH_SUPPLY_SETTLE);
        end else begin
            enter_phase(gms_pkg::PH_WAIT_RELEASE);
        end
    endfunction

    function automatic void halt_motion();
        duty_level  = 0;
        stop_done   = 1'b1;
        press_armed = 1'b0;
        press_ticks = '0;
        seq_kind    = gms_pkg::KIND_NONE;
        enter_phase(gms_pkg::PH_STOP_HOLD);
    endfunction

    function automatic void reset_sequencer_model();
        timeout_lim      = gms_pkg::TIMEOUT_MS_RST;
        slow_level       = gms_pkg::SLOW_DUTY_RST;
        supply_wait      = gms_pkg::SUPPLY_SETTLE_MS_RST;
        dir_wait         = gms_pkg::DIR_SETTLE_MS_RST;
        step_ticks       = gms_pkg::RAMP_STEP_MS_RST;
        hold_before_off  = gms_pkg::STOP_HOLD_MS_RST;
        full_run_len     = gms_pkg::FULL_RUN_MS_RST;
        partial_hold_len = gms_pkg::PARTIAL_HOLD_MS_RST;
        seq_phase   = gms_pkg::PH_IDLE;
        seq_kind    = gms_pkg::KIND_NONE;
        phase_ticks = '0;
        press_ticks = '0;
        press_armed = 1'b0;
        duty_level  = 0;
        dir_close   = 1'b1;
        supply_en   = 1'b0;
        stop_done   = 1'b0;
        close_prev  = 1'b0;
    endfunction

    // Advance the mirror by one millisecond tick and return the drive it produces
    function automatic drive_t advance_sequencer(input tick_t t);
        drive_t r;
        bit     cedge, tmo, brk, held;
        cedge = t.close_btn && !close_prev;
        if (press_armed) press_ticks = sat_inc(press_ticks);
        tmo = press_armed && (press_ticks >= timeout_lim);

        case (seq_phase)
            gms_pkg::PH_IDLE, gms_pkg::PH_PARTIAL_DONE, gms_pkg::PH_SLOW_RUN: begin
                if (t.partial_btn) begin_motion(gms_pkg::KIND_PARTIAL);
                else if (t.full_btn) begin_motion(gms_pkg::KIND_FULL);
                else if (cedge) begin_motion(gms_pkg::KIND_CLOSE);
                else if ((!stop_done && (t.limit || t.stop_btn)) || tmo) halt_motion();
            end
            gms_pkg::PH_WAIT_RELEASE: begin
                held = (seq_kind == gms_pkg::KIND_PARTIAL) ? t.partial_btn : t.full_btn;
                if (!held) begin
                    supply_en = 1'b1;
                    enter_phase(gms_pkg::PH_SUPPLY_SETTLE);
                end
            end
            gms_pkg::PH_SUPPLY_SETTLE: begin
                phase_ticks = sat_inc(phase_ticks);
                if (phase_ticks >= supply_wait) begin
                    dir_close = (seq_kind == gms_pkg::KIND_CLOSE);
                    enter_phase(gms_pkg::PH_DIR_SETTLE);
                end
            end
            gms_pkg::PH_DIR_SETTLE: begin
                phase_ticks = sat_inc(phase_ticks);
                if (phase_ticks >= dir_wait) begin
                    if (seq_kind == gms_pkg::KIND_CLOSE) begin
                        duty_level = slow_target();
                        enter_phase(gms_pkg::PH_CLOSE_RUN);
                    end else begin
                        duty_level = 0;
                        enter_phase(gms_pkg::PH_RAMP_RELEASE);
                    end
                end
            end
            gms_pkg::PH_RAMP_RELEASE, gms_pkg::PH_RAMP_CLOSE: begin
                phase_ticks = sat_inc(phase_ticks);
                if (phase_ticks >= step_span()) begin
                    phase_ticks = '0;
                    brk = ((seq_phase == gms_pkg::PH_RAMP_RELEASE) ? !t.limit : t.limit)
                          || t.stop_btn || tmo;
                    if (brk && seq_phase == gms_pkg::PH_RAMP_RELEASE) begin
                        enter_phase(gms_pkg::PH_RAMP_CLOSE);
                    end else if (brk || duty_level >= DUTY_FULL) begin
                        duty_level = DUTY_FULL;
                        if (seq_kind == gms_pkg::KIND_PARTIAL)
                            enter_phase(gms_pkg::PH_PARTIAL_HOLD);
                        else
                            enter_phase(gms_pkg::PH_FULL_RUN);
                    end else begin
                        duty_level++;
                    end
                end
            end
            gms_pkg::PH_PARTIAL_HOLD: begin
                duty_level = DUTY_FULL;
                if (t.limit || t.stop_btn || tmo || phase_ticks >= partial_hold_len) begin
                    duty_level = 0;
                    enter_phase(gms_pkg::PH_PARTIAL_DONE);
                end else begin
                    phase_ticks = sat_inc(phase_ticks);
                end
            end
            gms_pkg::PH_FULL_RUN: begin
                phase_ticks = sat_inc(phase_ticks);
                if (t.limit || t.stop_btn || tmo || phase_ticks >= full_run_len) begin
                    duty_level = slow_target();
                    enter_phase(gms_pkg::PH_SLOW_RUN);
                end
            end
            gms_pkg::PH_CLOSE_RUN: begin
                duty_level  = slow_target();
                phase_ticks = sat_inc(phase_ticks);
                if ((phase_ticks % step_span()) == 0 &&
                    (!t.limit || t.stop_btn || tmo ||
                     phase_ticks >= CLOSE_RUN_STEPS * step_span()))
                    enter_phase(gms_pkg::PH_SLOW_RUN);
            end
            gms_pkg::PH_STOP_HOLD: begin
                duty_level  = 0;
                phase_ticks = sat_inc(phase_ticks);
                if (phase_ticks >= hold_before_off) begin
                    supply_en = 1'b0;
                    enter_phase(gms_pkg::PH_IDLE);
                end
            end
            default: enter_phase(gms_pkg::PH_IDLE);
        endcase

        close_prev  = t.close_btn;
        r.duty      = duty_level[DUTY_W-1:0];
        r.dir_close = dir_close;
        r.supply    = supply_en;
        r.stopped   = stop_done;
        r.phase     = seq_phase;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    // Predict on each accepted tick, compare each accepted result
    always @(posedge aclk) begin
        drive_t want;
        if (aresetn) begin
            if (s_valid && s_ready)
                expected_drive.push_back(advance_sequencer({s_partial_open_button,
                    s_full_open_button, s_close_button, s_stop_button, s_limit_switch}));
            if (m_valid && m_ready) begin
                results_seen++;
                if (expected_drive.size() == 0) begin
                    report_mismatch("unexpected result, phase", m_phase, 0);
                end else begin
                    want = expected_drive.pop_front();
                    if (m_pwm_duty !== want.duty)
                        report_mismatch("pwm_duty", m_pwm_duty, want.duty);
                    if (m_direction_close !== want.dir_close)
                        report_mismatch("direction_close", m_direction_close, want.dir_close);
                    if (m_supply_on !== want.supply)
                        report_mismatch("supply_on", m_supply_on, want.supply);
                    if (m_motor_stopped !== want.stopped)
                        report_mismatch("motor_stopped", m_motor_stopped, want.stopped);
                    if (m_phase !== want.phase)
                        report_mismatch("phase", m_phase, want.phase);
                end
            end
        end
    end

    // Result side: random stalls, plus a long hold-off on request
    always @(posedge aclk) begin
        if (stall_orders != stall_seen) begin
            stall_seen <= stall_orders;
            stall_left <= LONG_STALL;
            m_ready    <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Offer one tick item and hold it until taken
    task automatic send_tick(input tick_t t);
        if ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_valid               <= 1'b1;
        s_partial_open_button <= t.partial_btn;
        s_full_open_button    <= t.full_btn;
        s_close_button        <= t.close_btn;
        s_stop_button         <= t.stop_btn;
        s_limit_switch        <= t.limit;
        do @(posedge aclk); while (!(s_valid && s_ready));
        ticks_sent++;
    endtask

    task automatic tick(input bit pa, input bit fu, input bit cl, input bit sb, input bit ls);
        send_tick('{pa, fu, cl, sb, ls});
    endtask

    // Stop offering and wait until every result has come back
    task automatic drain_results();
        s_valid <= 1'b0;
        while (results_seen != ticks_sent) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    // Write one register and mirror it once the write is taken
    task automatic write_reg(input logic [gms_pkg::CFG_INDEX_W-1:0] index,
                             input logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
        case (index)
            gms_pkg::CFG_TIMEOUT:       timeout_lim      = data;
            gms_pkg::CFG_SLOW_DUTY:     slow_level       = data[7:0];
            gms_pkg::CFG_SUPPLY_SETTLE: supply_wait      = data;
            gms_pkg::CFG_DIR_SETTLE:    dir_wait         = data;
            gms_pkg::CFG_RAMP_STEP:     step_ticks       = data[7:0];
            gms_pkg::CFG_STOP_HOLD:     hold_before_off  = data;
            gms_pkg::CFG_FULL_RUN:      full_run_len     = data;
            gms_pkg::CFG_PARTIAL_HOLD:  partial_hold_len = data;
            default: ;
        endcase
        @(posedge aclk);
    endtask

    // Short timings so that random sequences get through every phase
    task automatic load_random_timing();
        logic [7:0] junk;
        drain_results();
        junk = 8'($urandom);
        write_reg(gms_pkg::CFG_TIMEOUT, 16'($urandom_range(10, 120)));
        write_reg(gms_pkg::CFG_SLOW_DUTY, {junk, 8'($urandom_range(255))});
        write_reg(gms_pkg::CFG_SUPPLY_SETTLE, 16'($urandom_range(0, 4)));
        write_reg(gms_pkg::CFG_DIR_SETTLE, 16'($urandom_range(0, 4)));
        write_reg(gms_pkg::CFG_RAMP_STEP,
                  {~junk, ($urandom_range(3) == 0) ? 8'd0 : 8'($urandom_range(1, 3))});
        write_reg(gms_pkg::CFG_STOP_HOLD, 16'($urandom_range(0, 6)));
        write_reg(gms_pkg::CFG_FULL_RUN, 16'($urandom_range(0, 20)));
        write_reg(gms_pkg::CFG_PARTIAL_HOLD, 16'($urandom_range(0, 10)));
    endtask

    // One press, then the gate travelling with the switch leaving and reaching an end
    task automatic run_motion_sequence();
        gms_pkg::motion_kind_t pick;
        tick_t                 t;
        int                    press_len, run_len, release_at, reclose_at;
        pick       = gms_pkg::motion_kind_t'($urandom_range(gms_pkg::KIND_PARTIAL,
                                                            gms_pkg::KIND_CLOSE));
        press_len  = $urandom_range(1, 3);
        run_len    = $urandom_range(8, 60);
        release_at = press_len + $urandom_range(0, run_len / 2);
        reclose_at = release_at + $urandom_range(1, run_len);
        for (int i = 0; i < press_len + run_len; i++) begin
            t       = '0;
            t.limit = (i < release_at) || (i >= reclose_at);
            if (i < press_len) begin
                case (pick)
                    gms_pkg::KIND_PARTIAL: t.partial_btn = 1'b1;
                    gms_pkg::KIND_FULL:    t.full_btn    = 1'b1;
                    default:               t.close_btn   = 1'b1;
                endcase
            end
            t.stop_btn = ($urandom_range(39) == 0);
            send_tick(t);
        end
    endtask

    // Reset values: idle tick, stop while idle into the stop hold, then a limit tick in the hold
    task automatic test_reset_defaults();
        tick(0, 0, 0, 0, 0);
        tick(0, 0, 0, 1, 0);
        tick(0, 0, 0, 0, 1);
    endtask

    // Partial open with all three buttons pressed at once, then the limit stop
    task automatic test_partial_open();
        drain_results();
        write_reg(gms_pkg::CFG_SUPPLY_SETTLE, 16'd0);
        write_reg(gms_pkg::CFG_DIR_SETTLE, 16'd1);
        write_reg(gms_pkg::CFG_RAMP_STEP, 16'd1);
        write_reg(gms_pkg::CFG_PARTIAL_HOLD, 16'd2);
        write_reg(gms_pkg::CFG_STOP_HOLD, 16'd1);
        tick(0, 0, 0, 0, 1);
        tick(1, 1, 1, 0, 1);
        tick(1, 0, 0, 0, 1);
        tick(0, 1, 0, 0, 1);
        tick(0, 0, 0, 0, 1);
        tick(0, 0, 0, 0, 1);
        tick(0, 0, 0, 0, 1);
        tick(0, 0, 0, 0, 0);
        tick(0, 0, 0, 0, 0);
        tick(0, 0, 0, 0, 1);
        repeat (3) tick(0, 0, 0, 0, 0);
        tick(0, 0, 0, 0, 1);
    endtask

    // Close on a press edge, held button gives no new edge, timeout ends it
    task automatic test_close_timeout();
        drain_results();
        write_reg(gms_pkg::CFG_TIMEOUT, 16'd9);
        tick(0, 0, 0, 0, 1);
        tick(0, 0, 1, 0, 1);
        repeat (12) tick(0, 0, 1, 0, 1);
    endtask

    // All registers at their minimum, then at their maximum, plus an unmapped index
    task automatic test_register_extremes();
        drain_results();
        for (int r = gms_pkg::CFG_TIMEOUT; r <= gms_pkg::CFG_PARTIAL_HOLD; r++)
            write_reg(r[3:0], 16'h0000);
        tick(0, 0, 0, 0, 0);
        tick(0, 1, 0, 0, 0);
        tick(0, 0, 0, 0, 0);
        repeat (3) tick(0, 0, 0, 0, 0);
        repeat (4) tick(0, 0, 0, 0, 1);
        drain_results();
        for (int r = gms_pkg::CFG_TIMEOUT; r <= gms_pkg::CFG_PARTIAL_HOLD; r++)
            write_reg(r[3:0], 16'hFFFF);
        write_reg(UNMAPPED_REG, 16'h0000);
        tick(0, 0, 0, 0, 0);
        tick(0, 0, 1, 0, 1);
        tick(0, 0, 0, 1, 1);
    endtask

    // Ramp that never sees the switch release climbs to full duty
    task automatic test_ramp_to_full();
        drain_results();
        write_reg(gms_pkg::CFG_TIMEOUT, 16'hFFFF);
        write_reg(gms_pkg::CFG_SUPPLY_SETTLE, 16'd1);
        write_reg(gms_pkg::CFG_DIR_SETTLE, 16'd1);
        write_reg(gms_pkg::CFG_RAMP_STEP, 16'd1);
        write_reg(gms_pkg::CFG_SLOW_DUTY, 16'd30);
        write_reg(gms_pkg::CFG_FULL_RUN, 16'd3);
        write_reg(gms_pkg::CFG_PARTIAL_HOLD, 16'd4);
        write_reg(gms_pkg::CFG_STOP_HOLD, 16'd2);
        repeat (6) tick(0, 0, 0, 0, 0);
        tick(0, 1, 0, 0, 1);
        repeat (266) tick(0, 0, 0, 0, 1);
    endtask

    // Close run with the switch never releasing ends after the step limit
    task automatic test_close_run_limit();
        tick(0, 0, 1, 0, 1);
        repeat (262) tick(0, 0, 1, 0, 1);
    endtask

    // Mostly well-formed motions, some noise bursts
    task automatic test_random_traffic(input int count);
        int         goal;
        logic [4:0] noise;
        goal = ticks_sent + count;
        while (ticks_sent < goal) begin
            if ($urandom_range(99) < 85) begin
                run_motion_sequence();
            end else begin
                repeat ($urandom_range(1, 8)) begin
                    noise = 5'($urandom_range(31));
                    send_tick(noise);
                end
            end
        end
    endtask

    // Hold the result side off while ticks keep coming, so the input backs up
    task automatic test_output_stall();
        logic [4:0] noise;
        tx_idle_pct = 0;
        stall_orders <= stall_orders + 1;
        repeat (20) begin
            noise = 5'($urandom_range(31));
            send_tick(noise);
        end
    endtask

    initial begin
        reset_sequencer_model();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        test_reset_defaults();
        test_partial_open();
        test_close_timeout();
        test_register_extremes();
        test_ramp_to_full();
        test_close_run_limit();

        load_random_timing();
        test_random_traffic(20);

        tx_idle_pct = 74;
        rx_idle_pct = 30;
        load_random_timing();
        test_random_traffic(20);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        load_random_timing();
        test_random_traffic(20);
        test_output_stall();

        drain_results();
        repeat (20) @(posedge aclk);
        if (expected_drive.size() != 0)
            report_mismatch("leftover expectations", expected_drive.size(), 0);
        if (fail_count == 0) begin
            $display("PASS gate_motor_sequencer_top");
        end else begin
            $display("FAIL gate_motor_sequencer_top");
        end
        $finish;
    end

    // Give up if the run hangs
    initial begin
        #2ms;
        $display("FAIL gate_motor_sequencer_top");
        $finish;
    end

endmodule
